// ===== src/alc_pkg.sv =====
// Shared types and constants for the ambient light dimmer controller.
// Used by every module in src; depends on nothing.
package alc_pkg;

  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 8;
  localparam int PHASE_W  = 3;
  localparam int IDX_W    = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_DARK_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_STICK_HIGH     = 3'd1;
  localparam logic [IDX_W-1:0] REG_STICK_LOW      = 3'd2;
  localparam logic [IDX_W-1:0] REG_LEAVE_TIMEOUT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ON_LEVEL       = 3'd4;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] DARK_THRESHOLD_RST = 10'd750;
  localparam logic [SAMPLE_W-1:0] STICK_HIGH_RST     = 10'd950;
  localparam logic [SAMPLE_W-1:0] STICK_LOW_RST      = 10'd50;
  localparam logic [LEVEL_W-1:0]  LEAVE_TIMEOUT_RST  = 8'd20;
  localparam logic [LEVEL_W-1:0]  ON_LEVEL_RST       = 8'd128;

  // Compare level values: 255 is dark, lower is brighter.
  localparam logic [LEVEL_W-1:0] LEVEL_DARK     = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_DIM_MAX  = 8'd253;
  localparam logic [LEVEL_W-1:0] LEVEL_STEP     = 8'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT   = 8'd0;

  // Phase codes reported on the result word.
  localparam logic [PHASE_W-1:0] AP_INIT     = 3'd0;
  localparam logic [PHASE_W-1:0] AP_WAIT     = 3'd1;
  localparam logic [PHASE_W-1:0] AP_ON       = 3'd2;
  localparam logic [PHASE_W-1:0] AP_LEAVE    = 3'd3;
  localparam logic [PHASE_W-1:0] AP_SWAP     = 3'd4;
  localparam logic [PHASE_W-1:0] AP_IDLE     = 3'd5;
  localparam logic [PHASE_W-1:0] AP_TURN_ON  = 3'd6;
  localparam logic [PHASE_W-1:0] AP_TURN_OFF = 3'd7;

  localparam logic [PHASE_W-1:0] SP_INIT   = 3'd0;
  localparam logic [PHASE_W-1:0] SP_AUTO   = 3'd1;
  localparam logic [PHASE_W-1:0] SP_POWER  = 3'd2;
  localparam logic [PHASE_W-1:0] SP_OFF    = 3'd3;
  localparam logic [PHASE_W-1:0] SP_SWAP   = 3'd4;
  localparam logic [PHASE_W-1:0] SP_SW_ON  = 3'd5;
  localparam logic [PHASE_W-1:0] SP_SW_OFF = 3'd6;
  localparam logic [PHASE_W-1:0] SP_HOLD   = 3'd7;

  typedef enum logic [7:0] {
    A_INIT     = 8'b0000_0001,
    A_WAIT     = 8'b0000_0010,
    A_ON       = 8'b0000_0100,
    A_LEAVE    = 8'b0000_1000,
    A_SWAP     = 8'b0001_0000,
    A_IDLE     = 8'b0010_0000,
    A_TURN_ON  = 8'b0100_0000,
    A_TURN_OFF = 8'b1000_0000
  } auto_state_t;

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_AUTO   = 8'b0000_0010,
    S_POWER  = 8'b0000_0100,
    S_OFF    = 8'b0000_1000,
    S_SWAP   = 8'b0001_0000,
    S_SW_ON  = 8'b0010_0000,
    S_SW_OFF = 8'b0100_0000,
    S_HOLD   = 8'b1000_0000
  } switch_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dark_threshold;
    logic [SAMPLE_W-1:0] stick_high;
    logic [SAMPLE_W-1:0] stick_low;
    logic [LEVEL_W-1:0]  leave_timeout;
    logic [LEVEL_W-1:0]  on_level;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] light_sample;
    logic [SAMPLE_W-1:0] stick_x;
    logic                motion_present;
    logic                mode_button;
    logic                power_switch;
  } item_t;

  typedef struct packed {
    auto_state_t        auto_state;
    switch_state_t      switch_state;
    logic               stick_started;
    logic [LEVEL_W-1:0] idle_count;
    logic               manual_flag;
    logic [LEVEL_W-1:0] duty_level;
    logic               lamp_flag;
  } ctrl_state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] duty_compare;
    logic               lamp_on;
    logic               manual_mode;
    logic [PHASE_W-1:0] auto_phase;
    logic [PHASE_W-1:0] switch_phase;
  } result_t;

endpackage

// ===== src/alc_in_stage.sv =====
// Input register for the dimmer controller: holds one accepted word.
// Depends on alc_pkg.
module alc_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  alc_pkg::item_t in_item,
  input  logic           take,
  output logic           held_valid,
  output alc_pkg::item_t held_item
);

  // A word may enter when none is held or the held one leaves this cycle.
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== src/alc_step.sv =====
// Next-state and result logic for one tick: automatic, switch and joystick
// machines in order. Depends on alc_pkg.
module alc_step (
  input  alc_pkg::cfg_t        cfg,
  input  alc_pkg::ctrl_state_t cur,
  input  alc_pkg::item_t       item,
  output alc_pkg::ctrl_state_t nxt,
  output alc_pkg::result_t     res
);

  function automatic logic [alc_pkg::PHASE_W-1:0] auto_phase_of(
    alc_pkg::auto_state_t s);
    logic [alc_pkg::PHASE_W-1:0] p;
    unique case (s)
      alc_pkg::A_INIT:     p = alc_pkg::AP_INIT;
      alc_pkg::A_WAIT:     p = alc_pkg::AP_WAIT;
      alc_pkg::A_ON:       p = alc_pkg::AP_ON;
      alc_pkg::A_LEAVE:    p = alc_pkg::AP_LEAVE;
      alc_pkg::A_SWAP:     p = alc_pkg::AP_SWAP;
      alc_pkg::A_IDLE:     p = alc_pkg::AP_IDLE;
      alc_pkg::A_TURN_ON:  p = alc_pkg::AP_TURN_ON;
      alc_pkg::A_TURN_OFF: p = alc_pkg::AP_TURN_OFF;
      default:             p = alc_pkg::AP_INIT;
    endcase
    return p;
  endfunction

  function automatic logic [alc_pkg::PHASE_W-1:0] switch_phase_of(
    alc_pkg::switch_state_t s);
    logic [alc_pkg::PHASE_W-1:0] p;
    unique case (s)
      alc_pkg::S_INIT:   p = alc_pkg::SP_INIT;
      alc_pkg::S_AUTO:   p = alc_pkg::SP_AUTO;
      alc_pkg::S_POWER:  p = alc_pkg::SP_POWER;
      alc_pkg::S_OFF:    p = alc_pkg::SP_OFF;
      alc_pkg::S_SWAP:   p = alc_pkg::SP_SWAP;
      alc_pkg::S_SW_ON:  p = alc_pkg::SP_SW_ON;
      alc_pkg::S_SW_OFF: p = alc_pkg::SP_SW_OFF;
      alc_pkg::S_HOLD:   p = alc_pkg::SP_HOLD;
      default:           p = alc_pkg::SP_INIT;
    endcase
    return p;
  endfunction

  logic                   dark;
  logic                   motion;
  logic                   button;
  logic                   power;
  alc_pkg::auto_state_t   a_st;
  alc_pkg::switch_state_t s_st;
  logic [alc_pkg::LEVEL_W-1:0] idle;
  logic                   manual;
  logic [alc_pkg::LEVEL_W-1:0] duty;
  logic                   lamp;

  assign dark   = item.light_sample > cfg.dark_threshold;
  assign motion = item.motion_present;
  assign button = item.mode_button;
  assign power  = item.power_switch;

  always_comb begin
    idle   = cur.idle_count;
    manual = cur.manual_flag;
    duty   = cur.duty_level;
    lamp   = cur.lamp_flag;

    // Automatic machine.
    unique case (cur.auto_state)
      alc_pkg::A_INIT: a_st = alc_pkg::A_WAIT;
      alc_pkg::A_WAIT: begin
        if (dark) a_st = alc_pkg::A_WAIT;
        else if (motion) a_st = alc_pkg::A_TURN_ON;
        else if (button) a_st = alc_pkg::A_SWAP;
        else a_st = alc_pkg::A_WAIT;
      end
      alc_pkg::A_ON: begin
        if (dark) a_st = alc_pkg::A_WAIT;
        else if (motion) a_st = alc_pkg::A_ON;
        else if (button) a_st = alc_pkg::A_SWAP;
        else a_st = alc_pkg::A_LEAVE;
      end
      alc_pkg::A_LEAVE: begin
        if (dark) a_st = alc_pkg::A_WAIT;
        else if (motion) a_st = alc_pkg::A_ON;
        else if (button) a_st = alc_pkg::A_SWAP;
        else if (cur.idle_count >= cfg.leave_timeout) a_st = alc_pkg::A_TURN_OFF;
        else a_st = alc_pkg::A_LEAVE;
      end
      alc_pkg::A_SWAP: begin
        if (dark) a_st = alc_pkg::A_WAIT;
        else if (button) a_st = alc_pkg::A_SWAP;
        else if (!cur.manual_flag) a_st = alc_pkg::A_IDLE;
        else a_st = alc_pkg::A_WAIT;
      end
      alc_pkg::A_IDLE: begin
        if (dark) a_st = alc_pkg::A_WAIT;
        else if (button) a_st = alc_pkg::A_SWAP;
        else a_st = alc_pkg::A_IDLE;
      end
      alc_pkg::A_TURN_ON: a_st = alc_pkg::A_ON;
      default:            a_st = alc_pkg::A_WAIT;
    endcase

    unique case (a_st)
      alc_pkg::A_WAIT: begin
        manual = 1'b0;
        idle   = '0;
        duty   = alc_pkg::LEVEL_DARK;
        lamp   = 1'b0;
      end
      alc_pkg::A_ON:   idle = '0;
      alc_pkg::A_LEAVE: idle = cur.idle_count + 8'd1;
      alc_pkg::A_SWAP: idle = '0;
      alc_pkg::A_IDLE: manual = 1'b1;
      alc_pkg::A_TURN_ON: begin
        duty = cfg.on_level;
        lamp = 1'b1;
      end
      alc_pkg::A_TURN_OFF: begin
        duty = alc_pkg::LEVEL_DARK;
        lamp = 1'b0;
      end
      default: ;
    endcase

    // Switch machine; it sees the manual flag as the automatic one left it.
    unique case (cur.switch_state)
      alc_pkg::S_INIT: s_st = alc_pkg::S_AUTO;
      alc_pkg::S_AUTO: begin
        if (dark) s_st = alc_pkg::S_HOLD;
        else if (button) s_st = alc_pkg::S_SWAP;
        else s_st = alc_pkg::S_AUTO;
      end
      alc_pkg::S_POWER: begin
        if (dark) s_st = alc_pkg::S_HOLD;
        else if (button) s_st = alc_pkg::S_SWAP;
        else if (power) s_st = alc_pkg::S_POWER;
        else s_st = alc_pkg::S_SW_OFF;
      end
      alc_pkg::S_OFF: begin
        if (dark) s_st = alc_pkg::S_HOLD;
        else if (button) s_st = alc_pkg::S_SWAP;
        else if (power) s_st = alc_pkg::S_SW_ON;
        else s_st = alc_pkg::S_OFF;
      end
      alc_pkg::S_SWAP: begin
        if (dark) s_st = alc_pkg::S_HOLD;
        else if (button) s_st = alc_pkg::S_SWAP;
        else if (!manual) s_st = alc_pkg::S_AUTO;
        else s_st = alc_pkg::S_SW_OFF;
      end
      alc_pkg::S_SW_ON:  s_st = alc_pkg::S_POWER;
      alc_pkg::S_SW_OFF: s_st = alc_pkg::S_OFF;
      default: begin
        if (dark) s_st = alc_pkg::S_HOLD;
        else if (!manual) s_st = alc_pkg::S_AUTO;
        else s_st = alc_pkg::S_POWER;
      end
    endcase

    if (s_st == alc_pkg::S_OFF || s_st == alc_pkg::S_SW_OFF) begin
      duty = alc_pkg::LEVEL_DARK;
      lamp = 1'b0;
    end else if (s_st == alc_pkg::S_SW_ON) begin
      duty = cfg.on_level;
      lamp = 1'b1;
    end

    // Joystick machine acts from the second tick after reset.
    if (cur.stick_started) begin
      if (item.stick_x >= cfg.stick_high) begin
        if (duty != alc_pkg::LEVEL_DARK) begin
          duty = (duty >= alc_pkg::LEVEL_STEP) ? duty - alc_pkg::LEVEL_STEP
                                               : alc_pkg::LEVEL_BRIGHT;
        end
      end else if (item.stick_x <= cfg.stick_low) begin
        if (duty < alc_pkg::LEVEL_DIM_MAX) duty = duty + alc_pkg::LEVEL_STEP;
      end
    end
  end

  always_comb begin
    nxt.auto_state    = a_st;
    nxt.switch_state  = s_st;
    nxt.stick_started = 1'b1;
    nxt.idle_count    = idle;
    nxt.manual_flag   = manual;
    nxt.duty_level    = duty;
    nxt.lamp_flag     = lamp;

    res.duty_compare = duty;
    res.lamp_on      = lamp;
    res.manual_mode  = manual;
    res.auto_phase   = auto_phase_of(a_st);
    res.switch_phase = switch_phase_of(s_st);
  end

endmodule

// ===== src/ambient_light_dimmer_controller.sv =====
// Ambient light dimmer controller top level.
// A word passes from the input register to the result register.
// Throughput: one word per cycle; the input register and result register
// both advance whenever the result register is empty or being taken.
// Reset (rst, synchronous) loads register defaults and the machine start
// states, and empties both pipeline registers. Depends on alc_pkg.
module ambient_light_dimmer_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [alc_pkg::IDX_W-1:0]             wr_index,
  input  logic [alc_pkg::SAMPLE_W-1:0]          wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [alc_pkg::SAMPLE_W-1:0]          light_sample,
  input  logic [alc_pkg::SAMPLE_W-1:0]          stick_x,
  input  logic                                  motion_present,
  input  logic                                  mode_button,
  input  logic                                  power_switch,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [alc_pkg::LEVEL_W-1:0]           duty_compare,
  output logic                                  lamp_on,
  output logic                                  manual_mode,
  output logic [alc_pkg::PHASE_W-1:0]           auto_phase,
  output logic [alc_pkg::PHASE_W-1:0]           switch_phase
);

  alc_pkg::cfg_t        cfg;
  alc_pkg::ctrl_state_t st;
  alc_pkg::ctrl_state_t st_next;
  alc_pkg::item_t       in_item;
  alc_pkg::item_t       held_item;
  alc_pkg::result_t     res_next;
  alc_pkg::result_t     res;
  logic                 held_valid;
  logic                 take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dark_threshold <= alc_pkg::DARK_THRESHOLD_RST;
      cfg.stick_high     <= alc_pkg::STICK_HIGH_RST;
      cfg.stick_low      <= alc_pkg::STICK_LOW_RST;
      cfg.leave_timeout  <= alc_pkg::LEAVE_TIMEOUT_RST;
      cfg.on_level       <= alc_pkg::ON_LEVEL_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        alc_pkg::REG_DARK_THRESHOLD: cfg.dark_threshold <= wr_data;
        alc_pkg::REG_STICK_HIGH:     cfg.stick_high     <= wr_data;
        alc_pkg::REG_STICK_LOW:      cfg.stick_low      <= wr_data;
        alc_pkg::REG_LEAVE_TIMEOUT:  cfg.leave_timeout  <= wr_data[alc_pkg::LEVEL_W-1:0];
        alc_pkg::REG_ON_LEVEL:       cfg.on_level       <= wr_data[alc_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.light_sample   = light_sample;
  assign in_item.stick_x        = stick_x;
  assign in_item.motion_present = motion_present;
  assign in_item.mode_button    = mode_button;
  assign in_item.power_switch   = power_switch;

  // The held word moves on when the result register has room this cycle.
  assign take = held_valid && (!out_valid || out_ready);

  alc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  alc_step u_step (
    .cfg  (cfg),
    .cur  (st),
    .item (held_item),
    .nxt  (st_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.auto_state    <= alc_pkg::A_INIT;
      st.switch_state  <= alc_pkg::S_INIT;
      st.stick_started <= 1'b0;
      st.idle_count    <= '0;
      st.manual_flag   <= 1'b0;
      st.duty_level    <= alc_pkg::LEVEL_DARK;
      st.lamp_flag     <= 1'b0;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign duty_compare = res.duty_compare;
  assign lamp_on      = res.lamp_on;
  assign manual_mode  = res.manual_mode;
  assign auto_phase   = res.auto_phase;
  assign switch_phase = res.switch_phase;

endmodule

// ===== tb/ambient_light_dimmer_controller_tb.sv =====
// Testbench for the ambient light dimmer controller: drives sensor ticks through
// the valid/ready port, predicts every result word and checks it field by field.
// Depends on alc_pkg and the ambient_light_dimmer_controller top level.
`timescale 1ns / 1ps

module ambient_light_dimmer_controller_tb;
  import alc_pkg::*;

  localparam int QUIET_LIMIT = 500;
  localparam int MAX_GAP     = 17;
  localparam int SETTLE      = 4;
  localparam int ITEM_W      = $bits(item_t);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
  localparam logic [IDX_W-1:0] LAST_INDEX = {IDX_W{1'b1}};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_index;
  logic [SAMPLE_W-1:0] wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] light_sample;
  logic [SAMPLE_W-1:0] stick_x;
  logic                motion_present;
  logic                mode_button;
  logic                power_switch;
  logic                out_valid;
  logic                out_ready;
  logic [LEVEL_W-1:0]  duty_compare;
  logic                lamp_on;
  logic                manual_mode;
  logic [PHASE_W-1:0]  auto_phase;
  logic [PHASE_W-1:0]  switch_phase;

  ambient_light_dimmer_controller dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .light_sample(light_sample), .stick_x(stick_x), .motion_present(motion_present),
    .mode_button(mode_button), .power_switch(power_switch),
    .out_valid(out_valid), .out_ready(out_ready),
    .duty_compare(duty_compare), .lamp_on(lamp_on), .manual_mode(manual_mode),
    .auto_phase(auto_phase), .switch_phase(switch_phase)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted controller state and register copy.
  cfg_t               regs;
  logic [PHASE_W-1:0] auto_ph;
  logic [PHASE_W-1:0] switch_ph;
  logic               stick_armed;
  logic [LEVEL_W-1:0] idle_ticks;
  logic               manual_sel;
  logic [LEVEL_W-1:0] level;
  logic               lamp_lit;

  result_t expected_q[$];
  int      error_count = 0;

  // Random scene shaping; burst_mode is shared by sender and receiver.
  int   motion_pct = 0;
  logic power_held = 1'b0;
  bit   burst_mode = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    // Cap the log on a badly broken block; every mismatch still counts.
    if (error_count < 100)
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic void light_lamp(input logic lit);
    level    = lit ? regs.on_level : LEVEL_DARK;
    lamp_lit = lit;
  endfunction

  function automatic result_t advance_tick(input item_t t);
    logic               dark;
    logic [PHASE_W-1:0] nxt;
    result_t            r;
    dark = t.light_sample > regs.dark_threshold;

    case (auto_ph)
      AP_INIT: nxt = AP_WAIT;
      AP_WAIT: nxt = dark ? AP_WAIT : t.motion_present ? AP_TURN_ON :
                     t.mode_button ? AP_SWAP : AP_WAIT;
      AP_ON: nxt = dark ? AP_WAIT : t.motion_present ? AP_ON :
                   t.mode_button ? AP_SWAP : AP_LEAVE;
      AP_LEAVE: begin
        if (dark) nxt = AP_WAIT;
        else if (t.motion_present) nxt = AP_ON;
        else if (t.mode_button) nxt = AP_SWAP;
        else if (idle_ticks >= regs.leave_timeout) nxt = AP_TURN_OFF;
        else nxt = AP_LEAVE;
      end
      AP_SWAP: nxt = dark ? AP_WAIT : t.mode_button ? AP_SWAP :
                     !manual_sel ? AP_IDLE : AP_WAIT;
      AP_IDLE: nxt = dark ? AP_WAIT : t.mode_button ? AP_SWAP : AP_IDLE;
      AP_TURN_ON: nxt = AP_ON;
      default: nxt = AP_WAIT;
    endcase
    auto_ph = nxt;
    case (nxt)
      AP_WAIT: begin
        manual_sel = 1'b0;
        idle_ticks = '0;
        light_lamp(1'b0);
      end
      AP_ON, AP_SWAP: idle_ticks = '0;
      AP_LEAVE: idle_ticks = idle_ticks + 1'b1;
      AP_IDLE: manual_sel = 1'b1;
      AP_TURN_ON: light_lamp(1'b1);
      AP_TURN_OFF: light_lamp(1'b0);
      default: ;
    endcase

    // The switch machine sees the manual flag as the automatic machine left it.
    case (switch_ph)
      SP_INIT: nxt = SP_AUTO;
      SP_AUTO: nxt = dark ? SP_HOLD : t.mode_button ? SP_SWAP : SP_AUTO;
      SP_POWER: nxt = dark ? SP_HOLD : t.mode_button ? SP_SWAP :
                      t.power_switch ? SP_POWER : SP_SW_OFF;
      SP_OFF: nxt = dark ? SP_HOLD : t.mode_button ? SP_SWAP :
                    t.power_switch ? SP_SW_ON : SP_OFF;
      SP_SWAP: nxt = dark ? SP_HOLD : t.mode_button ? SP_SWAP :
                     !manual_sel ? SP_AUTO : SP_SW_OFF;
      SP_SW_ON: nxt = SP_POWER;
      SP_SW_OFF: nxt = SP_OFF;
      default: nxt = dark ? SP_HOLD : !manual_sel ? SP_AUTO : SP_POWER;
    endcase
    switch_ph = nxt;
    if (nxt == SP_OFF || nxt == SP_SW_OFF) light_lamp(1'b0);
    else if (nxt == SP_SW_ON) light_lamp(1'b1);

    // The joystick sits out the first tick after reset.
    if (stick_armed) begin
      if (t.stick_x >= regs.stick_high) begin
        if (level != LEVEL_DARK)
          level = (level >= LEVEL_STEP) ? level - LEVEL_STEP : LEVEL_BRIGHT;
      end else if (t.stick_x <= regs.stick_low) begin
        if (level < LEVEL_DIM_MAX) level = level + LEVEL_STEP;
      end
    end
    stick_armed = 1'b1;

    r.duty_compare = level;
    r.lamp_on      = lamp_lit;
    r.manual_mode  = manual_sel;
    r.auto_phase   = auto_ph;
    r.switch_phase = switch_ph;
    return r;
  endfunction

  function automatic item_t make_tick(input logic [SAMPLE_W-1:0] light,
                                      input logic [SAMPLE_W-1:0] x,
                                      input logic motion, input logic button,
                                      input logic power);
    item_t t;
    t.light_sample   = light;
    t.stick_x        = x;
    t.motion_present = motion;
    t.mode_button    = button;
    t.power_switch   = power;
    return t;
  endfunction

  // Mostly plausible room activity; a tenth of the words are raw noise.
  function automatic item_t random_tick();
    item_t t;
    t = ITEM_W'($urandom);
    if ($urandom_range(0, 9) == 0) return t;
    if (regs.dark_threshold < SAMPLE_MAX && $urandom_range(0, 99) < 6)
      t.light_sample = SAMPLE_W'($urandom_range(regs.dark_threshold + 1, SAMPLE_MAX));
    else
      t.light_sample = SAMPLE_W'($urandom_range(0, regs.dark_threshold));
    case ($urandom_range(0, 4))
      0, 1: t.stick_x = SAMPLE_W'($urandom_range(regs.stick_high, SAMPLE_MAX));
      2, 3: t.stick_x = SAMPLE_W'($urandom_range(0, regs.stick_low));
      default: t.stick_x = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    endcase
    t.motion_present = $urandom_range(0, 99) < motion_pct;
    t.mode_button    = $urandom_range(0, 99) < 8;
    if ($urandom_range(0, 99) < 15) power_held = !power_held;
    t.power_switch = power_held;
    return t;
  endfunction

  task automatic send_tick(input item_t t);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    light_sample   <= t.light_sample;
    stick_x        <= t.stick_x;
    motion_present <= t.motion_present;
    mode_button    <= t.mode_button;
    power_switch   <= t.power_switch;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(advance_tick(t));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_DARK_THRESHOLD: regs.dark_threshold = data;
      REG_STICK_HIGH:     regs.stick_high     = data;
      REG_STICK_LOW:      regs.stick_low      = data;
      REG_LEAVE_TIMEOUT:  regs.leave_timeout  = data[LEVEL_W-1:0];
      REG_ON_LEVEL:       regs.on_level       = data[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // Writes every register, with junk above the 8-bit ones and one write to an
  // unused index, which the block must ignore.
  task automatic program_regs(input logic [SAMPLE_W-1:0] dark, input logic [SAMPLE_W-1:0] high,
                              input logic [SAMPLE_W-1:0] low, input logic [LEVEL_W-1:0] timeout,
                              input logic [LEVEL_W-1:0] on_lvl);
    drain();
    write_reg(REG_DARK_THRESHOLD, dark);
    write_reg(REG_STICK_HIGH, high);
    write_reg(REG_STICK_LOW, low);
    write_reg(REG_LEAVE_TIMEOUT, {2'($urandom), timeout});
    write_reg(REG_ON_LEVEL, {2'($urandom), on_lvl});
    write_reg(IDX_W'($urandom_range(REG_ON_LEVEL + 1, LAST_INDEX)), SAMPLE_W'($urandom));
    wr_en <= 1'b0;
  endtask

  task automatic test_default_regs();
    send_tick(make_tick(0, 512, 0, 0, 0));
    send_tick(make_tick(750, SAMPLE_MAX, 1, 0, 0));
    send_tick(make_tick(100, 950, 1, 0, 0));
    send_tick(make_tick(100, 50, 0, 0, 0));
    send_tick(make_tick(751, 0, 0, 0, 1));
    send_tick(make_tick(0, 512, 0, 0, 0));
    send_tick(make_tick(0, 512, 0, 1, 0));
    send_tick(make_tick(0, 512, 0, 0, 0));
    send_tick(make_tick(0, 512, 0, 0, 1));
    send_tick(make_tick(0, 512, 0, 0, 1));
    send_tick(make_tick(0, SAMPLE_MAX, 0, 0, 1));
    send_tick(make_tick(0, 512, 0, 0, 0));
    send_tick(make_tick(SAMPLE_MAX, 512, 1, 1, 1));
  endtask

  // Saturation at full brightness, the dim ceiling, a lamp that cannot
  // brighten, and a zero leave timeout.
  task automatic test_level_limits();
    program_regs(SAMPLE_MAX - 1, SAMPLE_MAX, 0, 0, 3);
    send_tick(make_tick(SAMPLE_MAX, 512, 0, 0, 0));
    send_tick(make_tick(SAMPLE_MAX, 512, 0, 0, 0));
    send_tick(make_tick(0, 512, 0, 0, 0));
    send_tick(make_tick(0, SAMPLE_MAX, 1, 0, 0));
    send_tick(make_tick(0, SAMPLE_MAX, 1, 0, 0));
    send_tick(make_tick(0, SAMPLE_MAX, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 0));
    program_regs(SAMPLE_MAX - 1, SAMPLE_MAX, 0, 0, LEVEL_DARK);
    send_tick(make_tick(0, 512, 0, 0, 0));
    send_tick(make_tick(0, SAMPLE_MAX, 1, 0, 0));
    program_regs(SAMPLE_MAX - 1, SAMPLE_MAX, 0, 0, LEVEL_DIM_MAX);
    send_tick(make_tick(SAMPLE_MAX, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 1, 0, 0));
  endtask

  // Scenes of varied motion density; some run with no idling on either side.
  task automatic test_random_scenes(input int count, input bit pause_midway);
    int sent;
    int chunk;
    sent = 0;
    while (sent < count) begin
      chunk = $urandom_range(5, 40);
      case ($urandom_range(0, 3))
        0: motion_pct = 0;
        1: motion_pct = 10;
        2: motion_pct = 40;
        default: motion_pct = 90;
      endcase
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat (chunk) begin
        send_tick(random_tick());
        sent++;
      end
      if (pause_midway && sent >= count / 2) begin
        drain();
        pause_midway = 1'b0;
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin : stimulus
    wr_en          = 1'b0;
    wr_index       = '0;
    wr_data        = '0;
    in_valid       = 1'b0;
    light_sample   = '0;
    stick_x        = '0;
    motion_present = 1'b0;
    mode_button    = 1'b0;
    power_switch   = 1'b0;
    regs.dark_threshold = DARK_THRESHOLD_RST;
    regs.stick_high     = STICK_HIGH_RST;
    regs.stick_low      = STICK_LOW_RST;
    regs.leave_timeout  = LEAVE_TIMEOUT_RST;
    regs.on_level       = ON_LEVEL_RST;
    auto_ph     = AP_INIT;
    switch_ph   = SP_INIT;
    stick_armed = 1'b0;
    idle_ticks  = '0;
    manual_sel  = 1'b0;
    level       = LEVEL_DARK;
    lamp_lit    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_regs();
    test_level_limits();
    program_regs(DARK_THRESHOLD_RST, STICK_HIGH_RST, STICK_LOW_RST, 8'd20, ON_LEVEL_RST);
    test_random_scenes(160, 1'b1);
    program_regs(0, 0, 0, 1, 0);
    test_random_scenes(90, 1'b0);
    program_regs(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 8'd255, 8'd254);
    test_random_scenes(90, 1'b0);
    repeat (2) begin
      program_regs(SAMPLE_W'($urandom_range(400, SAMPLE_MAX)),
                   SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
                   SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
                   LEVEL_W'($urandom_range(1, 6)), LEVEL_W'($urandom));
      test_random_scenes(80, 1'b0);
    end

    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("ambient_light_dimmer_controller_tb: clean");
    else
      $display("ambient_light_dimmer_controller_tb: errors");
    $finish;
  end

  initial begin : result_checker
    result_t got;
    result_t want;
    int      stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.duty_compare = duty_compare;
      got.lamp_on      = lamp_on;
      got.manual_mode  = manual_mode;
      got.auto_phase   = auto_phase;
      got.switch_phase = switch_phase;
      if (expected_q.size() == 0) begin
        report_mismatch("word with nothing expected", int'(got), 0);
      end else begin
        want = expected_q.pop_front();
        if (got.duty_compare !== want.duty_compare)
          report_mismatch("duty_compare", int'(got.duty_compare), int'(want.duty_compare));
        if (got.lamp_on !== want.lamp_on)
          report_mismatch("lamp_on", int'(got.lamp_on), int'(want.lamp_on));
        if (got.manual_mode !== want.manual_mode)
          report_mismatch("manual_mode", int'(got.manual_mode), int'(want.manual_mode));
        if (got.auto_phase !== want.auto_phase)
          report_mismatch("auto_phase", int'(got.auto_phase), int'(want.auto_phase));
        if (got.switch_phase !== want.switch_phase)
          report_mismatch("switch_phase", int'(got.switch_phase), int'(want.switch_phase));
      end
    end
  end

  // Ends the run if no word moves on either port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || wr_en || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("ambient_light_dimmer_controller_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/alc_pkg.sv
src/alc_in_stage.sv
src/alc_step.sv
src/ambient_light_dimmer_controller.sv
tb/ambient_light_dimmer_controller_tb.sv
